/* src/psf_unicode_table_parser_unit_macros.svh */
// ----------------------------------------------------------------------------
// PSF unicode table parser assertion macros
// Shared concurrent assertion forms used by the parser modules.
// ----------------------------------------------------------------------------
`ifndef PSF_UNICODE_TABLE_PARSER_UNIT_MACROS_SVH
`define PSF_UNICODE_TABLE_PARSER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PSFUT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PSFUT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/psfut_pkg.sv */
// ----------------------------------------------------------------------------
// PSF unicode table parser package
// Byte classes, queue entry type and sizing constants shared by the modules.
// ----------------------------------------------------------------------------
package psfut_pkg;

  localparam logic [7:0] GLYPH_END_BYTE = 8'hFF;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  // Class of a byte taken on its own, before the sequence state is known.
  typedef enum logic [2:0] {
    BYTE_GLYPH_END,
    BYTE_ASCII,
    BYTE_LEAD2,
    BYTE_LEAD3,
    BYTE_LEAD4,
    BYTE_LEAD_ZERO
  } byte_kind_t;

  typedef struct packed {
    byte_kind_t  kind;
    logic [7:0]  data_byte;
    logic        table_start;
  } entry_t;

endpackage

/* src/psfut_ifs.sv */
// ----------------------------------------------------------------------------
// PSF unicode table parser channel interfaces
// Valid/ready channels for table bytes in and code point pairs out.
// ----------------------------------------------------------------------------
interface psfut_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       table_start;

  modport source (output valid, output data_byte, output table_start, input ready);
  modport sink   (input valid, input data_byte, input table_start, output ready);
endinterface

interface psfut_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] code_point;
  logic [15:0] glyph_index;

  modport source (output valid, output code_point, output glyph_index, input ready);
  modport sink   (input valid, input code_point, input glyph_index, output ready);
endinterface

/* src/psfut_front.sv */
// ----------------------------------------------------------------------------
// PSF unicode table parser front end
// Accepts table bytes, classifies them and pushes them into the queue.
// ----------------------------------------------------------------------------
module psfut_front (
  psfut_in_if.sink           in_ch,
  input  logic               q_full,
  output logic               q_push,
  output psfut_pkg::entry_t  q_entry
);

  psfut_pkg::byte_kind_t kind;

  // The class ignores any pending sequence; the back end decides whether
  // the byte is really a continuation.
  always_comb begin
    priority if (in_ch.data_byte == psfut_pkg::GLYPH_END_BYTE) begin
      kind = psfut_pkg::BYTE_GLYPH_END;
    end else if (!in_ch.data_byte[7]) begin
      kind = psfut_pkg::BYTE_ASCII;
    end else if (!in_ch.data_byte[5]) begin
      kind = psfut_pkg::BYTE_LEAD2;
    end else if (!in_ch.data_byte[4]) begin
      kind = psfut_pkg::BYTE_LEAD3;
    end else if (!in_ch.data_byte[3]) begin
      kind = psfut_pkg::BYTE_LEAD4;
    end else begin
      kind = psfut_pkg::BYTE_LEAD_ZERO;
    end
  end

  assign in_ch.ready          = !q_full;
  assign q_push               = in_ch.valid && !q_full;
  assign q_entry.kind         = kind;
  assign q_entry.data_byte    = in_ch.data_byte;
  assign q_entry.table_start  = in_ch.table_start;

endmodule

/* src/psfut_queue.sv */
// ----------------------------------------------------------------------------
// PSF unicode table parser queue
// Short FIFO of classified bytes between the front and back ends.
// ----------------------------------------------------------------------------
`include "psf_unicode_table_parser_unit_macros.svh"

module psfut_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  psfut_pkg::entry_t  push_entry,
  input  logic               pop,
  output psfut_pkg::entry_t  head_entry,
  output logic               full,
  output logic               empty
);

  localparam logic [psfut_pkg::QUEUE_PTR_W-1:0] LAST_PTR =
    psfut_pkg::QUEUE_PTR_W'(psfut_pkg::QUEUE_DEPTH - 1);
  localparam logic [psfut_pkg::QUEUE_CNT_W-1:0] FULL_CNT =
    psfut_pkg::QUEUE_CNT_W'(psfut_pkg::QUEUE_DEPTH);

  psfut_pkg::entry_t                   slot_r [psfut_pkg::QUEUE_DEPTH];
  logic [psfut_pkg::QUEUE_PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [psfut_pkg::QUEUE_PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [psfut_pkg::QUEUE_CNT_W-1:0]   count_r, count_nxt;

  assign full       = (count_r == FULL_CNT);
  assign empty      = (count_r == '0);
  assign head_entry = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

  `PSFUT_ASSERT_NOW(a_no_pop_empty, clk, rst_n, pop, count_r != '0, "queue popped while empty")
  `PSFUT_ASSERT_NOW(a_no_push_full, clk, rst_n, push, count_r != FULL_CNT, "queue pushed while full")
  `PSFUT_ASSERT_NEXT(a_count_track, clk, rst_n, push && !pop, count_r == $past(count_r) + 1'b1, "queue count did not grow on push")

endmodule

/* src/psfut_back.sv */
// ----------------------------------------------------------------------------
// PSF unicode table parser back end
// Runs the UTF-8 sequence state and glyph counter, and holds the result.
// ----------------------------------------------------------------------------
`include "psf_unicode_table_parser_unit_macros.svh"

module psfut_back (
  input  logic               clk,
  input  logic               rst_n,
  input  psfut_pkg::entry_t  head_entry,
  input  logic               q_empty,
  output logic               q_pop,
  psfut_out_if.source        out_ch
);

  logic [15:0] glyph_r, glyph_nxt;
  logic [1:0]  owed_r, owed_nxt;
  logic [15:0] partial_r, partial_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [15:0] out_cp_r, out_glyph_r;

  logic [15:0] glyph_cur, partial_cur;
  logic [1:0]  owed_cur;
  logic [7:0]  b;
  logic        emit;
  logic [15:0] emit_cp;

  // Take a new byte whenever the output register is free or being drained.
  assign q_pop = !q_empty && (!out_valid_r || out_ch.ready);
  assign b     = head_entry.data_byte;

  // A table start clears the state before the byte itself is used.
  always_comb begin
    glyph_cur   = head_entry.table_start ? '0 : glyph_r;
    owed_cur    = head_entry.table_start ? '0 : owed_r;
    partial_cur = head_entry.table_start ? '0 : partial_r;
  end

  always_comb begin
    glyph_nxt   = glyph_cur;
    owed_nxt    = owed_cur;
    partial_nxt = partial_cur;
    emit        = 1'b0;
    emit_cp     = '0;
    if (owed_cur != 2'd0) begin
      // Continuation bytes are taken by count, whatever their value.
      partial_nxt = {partial_cur[9:0], b[5:0]};
      owed_nxt    = owed_cur - 2'd1;
      emit        = (owed_cur == 2'd1);
      emit_cp     = {partial_cur[9:0], b[5:0]};
    end else begin
      unique case (head_entry.kind)
        psfut_pkg::BYTE_GLYPH_END: begin
          glyph_nxt = glyph_cur + 16'd1;
        end
        psfut_pkg::BYTE_ASCII: begin
          emit    = 1'b1;
          emit_cp = {8'd0, b};
        end
        psfut_pkg::BYTE_LEAD2: begin
          partial_nxt = {11'd0, b[4:0]};
          owed_nxt    = 2'd1;
        end
        psfut_pkg::BYTE_LEAD3: begin
          partial_nxt = {12'd0, b[3:0]};
          owed_nxt    = 2'd2;
        end
        psfut_pkg::BYTE_LEAD4: begin
          partial_nxt = {13'd0, b[2:0]};
          owed_nxt    = 2'd3;
        end
        psfut_pkg::BYTE_LEAD_ZERO: begin
          emit    = 1'b1;
          emit_cp = '0;
        end
        default: begin
          emit = 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (q_pop) begin
      out_valid_nxt = emit;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      glyph_r     <= '0;
      owed_r      <= '0;
      partial_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (q_pop) begin
        glyph_r   <= glyph_nxt;
        owed_r    <= owed_nxt;
        partial_r <= partial_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && emit) begin
      out_cp_r    <= emit_cp;
      out_glyph_r <= glyph_cur;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.code_point  = out_cp_r;
  assign out_ch.glyph_index = out_glyph_r;

  `PSFUT_ASSERT_NEXT(a_last_cont_emits, clk, rst_n, q_pop && !head_entry.table_start && owed_r == 2'd1, out_valid_r, "last continuation gave no result")
  `PSFUT_ASSERT_NEXT(a_glyph_step, clk, rst_n, q_pop && !head_entry.table_start && owed_r == 2'd0 && head_entry.kind == psfut_pkg::BYTE_GLYPH_END, glyph_r == $past(glyph_r) + 16'd1, "glyph end did not advance counter")
  `PSFUT_ASSERT_NEXT(a_start_lead2, clk, rst_n, q_pop && head_entry.table_start && head_entry.kind == psfut_pkg::BYTE_LEAD2, owed_r == 2'd1 && glyph_r == 16'd0, "table start lead byte left wrong state")

endmodule

/* src/psf_unicode_table_parser_unit.sv */
// A byte transferred in passes through a queue slot and then the output register on its way to out_ch.
// Throughput: one byte per cycle, sustained while the result side keeps taking.
// Rate is set by the back end's update of the sequence state on each popped byte.
// Reset (rst_n low, synchronous) clears the glyph counter, the sequence state,
// the queue and the output valid flag; there is no clearing pass.
// ----------------------------------------------------------------------------
// PSF unicode table parser unit
// Decodes the UTF-8 unicode table of a PSF2 font into (code point, glyph)
// pairs for a translation map.
// ----------------------------------------------------------------------------
module psf_unicode_table_parser_unit (
  input  logic         clk,
  input  logic         rst_n,
  psfut_in_if.sink     in_ch,
  psfut_out_if.source  out_ch
);

  // The front end only classifies the byte by its own bits: the byte 0xFF,
  // plain ASCII, and lead bytes that open 2-, 3- or 4-byte sequences, or
  // that give code point zero outright when bits 5, 4 and 3 are all set.
  // Whether a byte is really a continuation depends on the owed count that
  // the back end keeps, so that decision is made there.
  psfut_pkg::entry_t  push_entry;
  psfut_pkg::entry_t  head_entry;
  logic               q_push;
  logic               q_pop;
  logic               q_full;
  logic               q_empty;

  psfut_front u_front (
    .in_ch   (in_ch),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_entry (push_entry)
  );

  // The queue decouples the two ends so that a stalled result side does not
  // stop byte transfers until the queue itself fills.
  psfut_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (push_entry),
    .pop        (q_pop),
    .head_entry (head_entry),
    .full       (q_full),
    .empty      (q_empty)
  );

  // The back end applies a table start first, then either shifts in six
  // continuation bits or acts on the byte class. Finished pairs land in an
  // output register, which is refilled in the same cycle it is drained.
  psfut_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_entry (head_entry),
    .q_empty    (q_empty),
    .q_pop      (q_pop),
    .out_ch     (out_ch)
  );

endmodule

/* tb/psfut_pair_checker.sv */
// ----------------------------------------------------------------------------
// PSF unicode table parser pair checker
// Watches both channels, predicts the (code point, glyph) pairs from the
// table bytes transferred in, and compares every pair transferred out.
// ----------------------------------------------------------------------------
module psfut_pair_checker (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic [7:0]        in_data_byte,
  input  logic              in_table_start,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic [15:0]       out_code_point,
  input  logic [15:0]       out_glyph_index,
  output int unsigned       fail_count,
  output int unsigned       pairs_outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [15:0] code_point;
    logic [15:0] glyph_index;
  } map_pair_t;

  // Decoder state as the block should hold it.
  logic [15:0] glyph_num;
  logic [1:0]  owed;
  logic [15:0] partial_cp;

  map_pair_t expected_pairs[$];

  // Runs one table byte through the decoder and queues the pair it yields.
  task automatic absorb_table_byte(input logic [7:0] b, input logic first);
    psfut_pkg::byte_kind_t kind;
    if (first) begin
      glyph_num  = '0;
      owed       = '0;
      partial_cp = '0;
    end
    // Inside a sequence every byte counts as a continuation, whatever it is.
    if (owed != 2'd0) begin
      partial_cp = {partial_cp[9:0], b[5:0]};
      owed       = owed - 2'd1;
      if (owed == 2'd0) begin
        expected_pairs.push_back('{code_point: partial_cp, glyph_index: glyph_num});
      end
      return;
    end
    if (b == psfut_pkg::GLYPH_END_BYTE) kind = psfut_pkg::BYTE_GLYPH_END;
    else if (!b[7])                     kind = psfut_pkg::BYTE_ASCII;
    else if (!b[5])                     kind = psfut_pkg::BYTE_LEAD2;
    else if (!b[4])                     kind = psfut_pkg::BYTE_LEAD3;
    else if (!b[3])                     kind = psfut_pkg::BYTE_LEAD4;
    else                                kind = psfut_pkg::BYTE_LEAD_ZERO;
    case (kind)
      psfut_pkg::BYTE_GLYPH_END: begin
        glyph_num = glyph_num + 16'd1;
      end
      psfut_pkg::BYTE_ASCII: begin
        expected_pairs.push_back('{code_point: {8'd0, b}, glyph_index: glyph_num});
      end
      psfut_pkg::BYTE_LEAD2: begin
        partial_cp = {11'd0, b[4:0]};
        owed       = 2'd1;
      end
      psfut_pkg::BYTE_LEAD3: begin
        partial_cp = {12'd0, b[3:0]};
        owed       = 2'd2;
      end
      psfut_pkg::BYTE_LEAD4: begin
        partial_cp = {13'd0, b[2:0]};
        owed       = 2'd3;
      end
      default: begin
        expected_pairs.push_back('{code_point: 16'd0, glyph_index: glyph_num});
      end
    endcase
  endtask

  always @(posedge clk) begin
    map_pair_t want;
    if (!rst_n) begin
      glyph_num         = '0;
      owed              = '0;
      partial_cp        = '0;
      fail_count        = 0;
      pairs_outstanding = 0;
      expected_pairs.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_pairs.size() == 0) begin
          $display("%0t: unexpected pair code_point=%h glyph_index=%h",
                   $time, out_code_point, out_glyph_index);
          fail_count++;
        end else begin
          want = expected_pairs.pop_front();
          if (out_code_point !== want.code_point) begin
            $display("%0t: code_point mismatch, expected %h, got %h",
                     $time, want.code_point, out_code_point);
            fail_count++;
          end
          if (out_glyph_index !== want.glyph_index) begin
            $display("%0t: glyph_index mismatch, expected %h, got %h",
                     $time, want.glyph_index, out_glyph_index);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready) begin
        absorb_table_byte(in_data_byte, in_table_start);
      end
      pairs_outstanding = expected_pairs.size();
    end
  end

endmodule

/* tb/tb_psf_unicode_table_parser_unit.sv */
// ----------------------------------------------------------------------------
// PSF unicode table parser unit testbench
// Feeds unicode table bytes to the parser with random gaps and stalls on both
// channels; a checker beside the block predicts and compares every pair.
// ----------------------------------------------------------------------------
module tb_psf_unicode_table_parser_unit;
  timeunit 1ns;
  timeprecision 1ps;

  // Table bytes for the whole run, and the long receiver hold-off.
  localparam int unsigned TOTAL_BYTES     = 1750;
  localparam int unsigned HOLD_OFF_CYCLES = 120;
  // Cycles without any transfer before the run is declared hung. The longest
  // legitimate quiet stretch is the hold-off above plus one long gap.
  localparam int unsigned WATCHDOG_LIMIT  = 2000;

  logic clk;
  logic rst_n;

  psfut_in_if  in_ch ();
  psfut_out_if out_ch ();

  int unsigned fail_count;
  int unsigned pairs_outstanding;

  // Steady flags switch off the random gaps of one side for a stretch, so
  // that back-to-back transfers get exercised too.
  logic sender_steady;
  logic taker_steady;
  // Set by the stimulus to ask the result side for one long hold-off.
  logic hold_off_req;

  int unsigned bytes_sent;

  psf_unicode_table_parser_unit u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  psfut_pair_checker u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_ch.valid),
    .in_ready          (in_ch.ready),
    .in_data_byte      (in_ch.data_byte),
    .in_table_start    (in_ch.table_start),
    .out_valid         (out_ch.valid),
    .out_ready         (out_ch.ready),
    .out_code_point    (out_ch.code_point),
    .out_glyph_index   (out_ch.glyph_index),
    .fail_count        (fail_count),
    .pairs_outstanding (pairs_outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Gap length for either side: mostly none or short, now and then long.
  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Offers one table byte and returns at the falling edge after its transfer.
  // A gap, if any, is taken with valid low before the byte is offered, so
  // valid is assigned only once per falling edge.
  task automatic send_byte(input logic [7:0] b, input logic first);
    int unsigned idle;
    idle = sender_steady ? 0 : gap_len();
    if (idle != 0) begin
      in_ch.valid <= 1'b0;
      repeat (idle) @(negedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.data_byte   <= b;
    in_ch.table_start <= first;
    do @(posedge clk); while (!in_ch.ready);
    bytes_sent++;
    @(negedge clk);
  endtask

  // Encodes a code point as a UTF-8 style sequence of the given length. The
  // bits the decoder ignores (bit 6 of a lead, the top two of a continuation)
  // are random, so that every bit of the byte field toggles.
  task automatic send_code_point(input logic [20:0] cp, input int unsigned len);
    logic       lead_spare;
    logic [1:0] t1;
    logic [1:0] t2;
    logic [1:0] t3;
    lead_spare = 1'($urandom_range(0, 1));
    t1         = 2'($urandom_range(0, 3));
    t2         = 2'($urandom_range(0, 3));
    t3         = 2'($urandom_range(0, 3));
    case (len)
      1: begin
        send_byte({1'b0, cp[6:0]}, 1'b0);
      end
      2: begin
        send_byte({1'b1, lead_spare, 1'b0, cp[10:6]}, 1'b0);
        send_byte({t1, cp[5:0]}, 1'b0);
      end
      3: begin
        send_byte({1'b1, lead_spare, 2'b10, cp[15:12]}, 1'b0);
        send_byte({t1, cp[11:6]}, 1'b0);
        send_byte({t2, cp[5:0]}, 1'b0);
      end
      default: begin
        send_byte({1'b1, lead_spare, 3'b110, cp[20:18]}, 1'b0);
        send_byte({t1, cp[17:12]}, 1'b0);
        send_byte({t2, cp[11:6]}, 1'b0);
        send_byte({t3, cp[5:0]}, 1'b0);
      end
    endcase
  endtask

  // Result side: random stalls, steady stretches, and one long hold-off on
  // request. The hold-off is counted here, in cycles, while the stimulus
  // keeps offering bytes, so the block's queue fills and it stalls its input.
  initial begin : result_taker
    int unsigned stall_left;
    stall_left   = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        stall_left   = HOLD_OFF_CYCLES;
      end else if (stall_left == 0 && !taker_steady && $urandom_range(0, 3) == 0) begin
        stall_left = gap_len();
      end
      if (stall_left != 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Watchdog: any transfer on either channel restarts the count.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, quiet);
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int unsigned pick;
    int unsigned n;
    int unsigned len;
    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.data_byte   = 8'h00;
    in_ch.table_start = 1'b0;
    sender_steady     = 1'b0;
    taker_steady      = 1'b0;
    hold_off_req      = 1'b0;
    bytes_sent        = 0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part. The first byte starts a table; the lowest and highest
    // single-byte code points come first for glyph zero.
    send_byte(8'h00, 1'b1);
    send_byte(8'h7F, 1'b0);
    // Glyph end moves on to glyph one.
    send_byte(psfut_pkg::GLYPH_END_BYTE, 1'b0);
    // A regular two-byte sequence.
    send_byte(8'hC3, 1'b0);
    send_byte(8'hA9, 1'b0);
    // A lead byte that looks like a continuation still opens a two-byte
    // sequence, and a glyph end byte inside it is only a continuation.
    send_byte(8'h85, 1'b0);
    send_byte(psfut_pkg::GLYPH_END_BYTE, 1'b0);
    // Three-byte sequence.
    send_byte(8'hE2, 1'b0);
    send_byte(8'h82, 1'b0);
    send_byte(8'hAC, 1'b0);
    // Four-byte sequence whose value exceeds 16 bits and gets truncated.
    send_byte(8'hF4, 1'b0);
    send_byte(8'h8F, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hBF, 1'b0);
    // Leads with bits 5, 4 and 3 set give code point zero at once.
    send_byte(8'hF8, 1'b0);
    send_byte(8'hFE, 1'b0);
    // Plain ASCII taken as a continuation, then a table start in the middle
    // of the sequence drops it and restarts glyph numbering.
    send_byte(8'hE0, 1'b0);
    send_byte(8'h41, 1'b0);
    send_byte(8'h41, 1'b1);

    // Glyph counter run: a few hundred glyph ends back to back, with a code
    // point now and then to check the counter along the way.
    sender_steady = 1'b1;
    send_byte(8'h30, 1'b1);
    for (int g = 1; g < 300; g++) begin
      send_byte(psfut_pkg::GLYPH_END_BYTE, 1'b0);
      if (g % 37 == 0) begin
        send_code_point(21'($urandom), $urandom_range(1, 4));
      end
    end
    send_byte(8'h41, 1'b0);
    send_byte(psfut_pkg::GLYPH_END_BYTE, 1'b0);
    send_byte(8'h42, 1'b0);

    // Long hold-off on the result side while bytes keep coming back to back.
    hold_off_req = 1'b1;
    for (int i = 0; i < 40; i++) begin
      send_byte(8'($urandom_range(0, 127)), 1'b0);
    end
    sender_steady = 1'b0;

    // Random part: mostly well-formed glyph entries with random code points,
    // plus noise, truncated sequences, zero leads and table restarts.
    while (bytes_sent < TOTAL_BYTES) begin
      if ($urandom_range(0, 49) == 0) begin
        sender_steady = ($urandom_range(0, 3) == 0);
        taker_steady  = ($urandom_range(0, 3) == 0);
      end
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        n = $urandom_range(0, 3);
        for (int k = 0; k < n; k++) begin
          send_code_point(21'($urandom), $urandom_range(1, 4));
        end
        send_byte(psfut_pkg::GLYPH_END_BYTE, 1'b0);
      end else if (pick < 80) begin
        n = $urandom_range(1, 4);
        for (int k = 0; k < n; k++) begin
          send_byte(8'($urandom), 1'b0);
        end
      end else if (pick < 88) begin
        // A sequence cut short by a table start.
        len = $urandom_range(2, 4);
        n   = $urandom_range(0, len - 2);
        send_byte(len == 2 ? {3'b110, 5'($urandom)} :
                  len == 3 ? {4'b1110, 4'($urandom)} : {5'b11110, 3'($urandom)}, 1'b0);
        for (int k = 0; k < n; k++) begin
          send_byte({2'b10, 6'($urandom)}, 1'b0);
        end
        send_byte(8'($urandom), 1'b1);
      end else if (pick < 94) begin
        send_byte(8'($urandom_range(8'hF8, 8'hFE)), 1'b0);
      end else begin
        send_byte(8'($urandom), 1'b1);
      end
    end
    in_ch.valid <= 1'b0;

    // Drain: wait for every predicted pair, then go on clocking to catch any
    // stray output the block might still produce.
    while (pairs_outstanding != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
